>>> rtl/bblru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bblru_pkg;

    localparam int unsigned ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_KEEP   = 2'd1,
        FUNC_TRIM   = 2'd2,
        FUNC_RELOAD = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] entry_key;
        logic [31:0] entry_bytes;
        logic [31:0] start_generation;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        stored;
        logic [4:0]  evicted_count;
        logic [31:0] total_bytes;
        logic [4:0]  entry_count;
        logic [31:0] current_generation;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_HIT,
        ST_DROP,
        ST_FULL,
        ST_FREE,
        ST_INSERT,
        ST_TRIM_CHK,
        ST_TRIM_FIND,
        ST_TRIM_DROP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/byte_budget_lru_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// size-weighted lru cache: up to ENTRIES keys with byte sizes under a budget
// input channel: i_in_valid / o_in_stall carrying a t_in_item (func, key,
// bytes, start generation); output channel: o_out_valid / i_out_stall with
// one t_out_item per input item
// config: i_cfg_we with i_cfg_wdata writes byte_budget; write only when idle
// one item at a time: an index sweep walks the slots one per cycle through a
// single key/rank compare unit; a lookup or keep sweeps for its key, and
// every budget eviction by keep or trim rescans for the oldest slot
// o_in_stall is high from the input transfer until the result is loaded into
// the output register, so the next item may be taken while a result waits
// the result sits in the output register while i_out_stall is high; a
// finished item waits in its done state until that register frees
// reset (synchronous, active low) empties the table, zeroes held bytes,
// generation and budget; no clearing pass is needed
module byte_budget_lru_cache_top #(
    parameter int unsigned ENTRIES = bblru_pkg::ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire bblru_pkg::t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output bblru_pkg::t_out_item      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    import bblru_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;
    t_in_item r_item;
    logic [31:0] r_budget, r_gen;
    logic [32:0] r_held;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx, r_sel;
    logic r_found;
    logic [IW-1:0] r_best_rank;
    logic [4:0] r_ev;
    logic r_hit, r_stored;
    logic r_out_valid;
    t_out_item r_out;
    logic [31:0] r_sel_bytes;

    logic w_match, w_valid;
    logic [IW-1:0] w_rank;
    logic [31:0] w_bytes;
    logic w_last, w_clear, w_remove, w_front, w_insert;
    logic [IW-1:0] w_scan;

    assign w_last = (r_idx == IW'(ENTRIES - 1));
    assign w_scan = r_idx;

    bblru_slots #(.ENTRIES(ENTRIES)) u_slots (
        .i_clk, .i_rst_n,
        .i_scan_idx(w_scan), .i_key(r_item.entry_key),
        .o_key_match(w_match), .o_valid(w_valid), .o_rank(w_rank), .o_bytes(w_bytes),
        .i_clear(w_clear), .i_remove(w_remove), .i_front(w_front), .i_insert(w_insert),
        .i_sel_idx(r_sel), .i_wr_bytes(r_item.entry_bytes)
    );

    logic w_keep_ok;
    assign w_keep_ok = (r_item.start_generation == r_gen) && (r_item.entry_bytes <= r_budget);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                unique case (t_func'(i_in_data.func))
                    FUNC_LOOKUP, FUNC_KEEP: n_state = ST_FIND;
                    FUNC_TRIM:              n_state = ST_TRIM_CHK;
                    default:                n_state = ST_DONE;
                endcase
            end
            ST_FIND: begin
                if (r_item.func == FUNC_KEEP && !w_keep_ok) n_state = ST_DONE;
                else if (w_match || w_last) begin
                    if (r_item.func == FUNC_LOOKUP)
                        n_state = (w_match) ? ST_HIT : ST_DONE;
                    else
                        n_state = (w_match) ? ST_DROP : ST_FULL;
                end
            end
            ST_HIT:  n_state = ST_DONE;
            ST_DROP: n_state = ST_FULL;
            ST_FULL: if (r_count < CW'(ENTRIES)) n_state = ST_FREE;
                     else if (w_last) n_state = ST_TRIM_DROP;
            ST_FREE: if (!w_valid || w_last) n_state = ST_INSERT;
            ST_INSERT:    n_state = ST_TRIM_CHK;
            ST_TRIM_CHK:  n_state = (r_held > {1'b0, r_budget} && r_count != '0)
                                    ? ST_TRIM_FIND : ST_DONE;
            ST_TRIM_FIND: if (w_last) n_state = ST_TRIM_DROP;
            ST_TRIM_DROP: n_state = (r_item.func == FUNC_KEEP && !r_stored)
                                    ? ST_FREE : ST_TRIM_CHK;
            ST_DONE: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs to the slot table
    always_comb begin
        w_clear = 1'b0; w_remove = 1'b0; w_front = 1'b0; w_insert = 1'b0;
        unique case (r_state)
            ST_HIT:       w_front  = 1'b1;
            ST_DROP:      w_remove = 1'b1;
            ST_TRIM_DROP: w_remove = 1'b1;
            ST_INSERT:    w_insert = 1'b1;
            ST_IDLE:      w_clear  = i_in_valid && i_in_data.func == FUNC_RELOAD;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // oldest-slot search keys: the valid slot with the largest rank
    logic w_better;
    assign w_better = w_valid && (!r_found || w_rank > r_best_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_budget <= '0; r_gen <= '0; r_held <= '0; r_count <= '0;
            r_out_valid <= 1'b0;
            r_idx <= '0; r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_budget <= i_cfg_wdata;
            // result register loads when free or draining this cycle
            if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_in_valid) begin
                    r_item <= i_in_data;
                    r_idx <= '0; r_found <= 1'b0;
                    r_hit <= 1'b0; r_stored <= 1'b0; r_ev <= '0;
                    if (i_in_data.func == FUNC_RELOAD) begin
                        r_held <= '0; r_count <= '0; r_gen <= r_gen + 32'd1;
                    end
                end
                ST_FIND: begin
                    if (w_match) r_sel <= r_idx;
                    r_idx <= (w_last || w_match) ? '0 : r_idx + 1'b1;
                end
                ST_HIT: r_hit <= 1'b1;
                ST_DROP: begin
                    r_held <= r_held - 33'(r_sel_bytes);
                    r_count <= r_count - 1'b1;
                end
                ST_FULL: if (r_count >= CW'(ENTRIES)) begin
                    if (w_better) begin r_sel <= r_idx; r_best_rank <= w_rank; r_found <= 1'b1; end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end else r_idx <= '0;
                ST_FREE: if (!w_valid || w_last) r_sel <= r_idx;
                         else r_idx <= r_idx + 1'b1;
                ST_INSERT: begin
                    r_held <= r_held + 33'(r_item.entry_bytes);
                    r_count <= r_count + 1'b1;
                    r_stored <= 1'b1;
                end
                ST_TRIM_CHK: begin r_idx <= '0; r_found <= 1'b0; end
                ST_TRIM_FIND: begin
                    if (w_better) begin r_sel <= r_idx; r_best_rank <= w_rank; r_found <= 1'b1; end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                ST_TRIM_DROP: begin
                    r_held <= r_held - 33'(r_sel_bytes);
                    r_count <= r_count - 1'b1;
                    if (r_ev != 5'd31) r_ev <= r_ev + 5'd1;
                    r_idx <= '0; r_found <= 1'b0;
                end
                ST_DONE: if (!r_out_valid || !i_out_stall) begin
                    r_out.hit <= r_hit;
                    r_out.stored <= r_stored;
                    r_out.evicted_count <= r_ev;
                    r_out.total_bytes <= r_held[31:0];
                    r_out.entry_count <= 5'(r_count);
                    r_out.current_generation <= r_gen;
                end
                default: ;
            endcase
        end
    end

    // bytes of the selected slot, captured whenever the key or oldest-slot scan picks it
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIND && w_match) ||
            ((r_state == ST_FULL || r_state == ST_TRIM_FIND) && w_better))
            r_sel_bytes <= w_bytes;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("entry count above table size");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> o_in_stall) else $error("ready while finishing");
    a_hit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> !r_out.stored) else $error("hit and stored");

endmodule
`default_nettype wire

>>> rtl/bblru_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// slot table: one entry examined per cycle through a shared compare unit
module bblru_slots #(
    parameter int unsigned ENTRIES = bblru_pkg::ENTRIES_DEF,
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [IW-1:0] i_scan_idx,
    input  wire logic [31:0]   i_key,
    output logic               o_key_match,
    output logic               o_valid,
    output logic [IW-1:0]      o_rank,
    output logic [31:0]        o_bytes,
    input  wire logic          i_clear,
    input  wire logic          i_remove,
    input  wire logic          i_front,
    input  wire logic          i_insert,
    input  wire logic [IW-1:0] i_sel_idx,
    input  wire logic [31:0]   i_wr_bytes
);
    logic [31:0]   r_key   [ENTRIES];
    logic [31:0]   r_bytes [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0] r_rank  [ENTRIES];
    logic [IW-1:0] w_sel_rank;

    assign w_sel_rank  = r_rank[i_sel_idx];
    assign o_valid     = r_valid[i_scan_idx];
    assign o_rank      = r_rank[i_scan_idx];
    assign o_bytes     = r_bytes[i_scan_idx];
    assign o_key_match = r_valid[i_scan_idx] && (r_key[i_scan_idx] == i_key);

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_key[i_sel_idx]   <= i_key;
            r_bytes[i_sel_idx] <= i_wr_bytes;
        end
    end

    // rank updates act on independent slots in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else if (i_remove) begin
            for (int i = 0; i < ENTRIES; i++)
                if (r_valid[i] && r_rank[i] > w_sel_rank) r_rank[i] <= r_rank[i] - 1'b1;
            r_valid[i_sel_idx] <= 1'b0;
            r_rank[i_sel_idx]  <= '0;
        end else if (i_front) begin
            for (int i = 0; i < ENTRIES; i++)
                if (r_valid[i] && r_rank[i] < w_sel_rank) r_rank[i] <= r_rank[i] + 1'b1;
            r_rank[i_sel_idx] <= '0;
        end else if (i_insert) begin
            for (int i = 0; i < ENTRIES; i++)
                if (r_valid[i]) r_rank[i] <= r_rank[i] + 1'b1;
            r_valid[i_sel_idx] <= 1'b1;
            r_rank[i_sel_idx]  <= '0;
        end
    end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bblru_pkg::*;

    localparam int unsigned SLOTS = ENTRIES_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic [31:0] i_cfg_wdata;

    byte_budget_lru_cache_top #(.ENTRIES(SLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // shadow copy of the cache used to predict each result
    logic [31:0] budget_q;
    logic [31:0] key_q [SLOTS];
    logic [31:0] size_q [SLOTS];
    bit          live_q [SLOTS];
    int unsigned rank_q [SLOTS];
    logic [32:0] held_q;
    logic [31:0] gen_q;

    t_out_item   expected_results [$];
    int          fail_count;
    longint      cycle_count = 0;
    bit          hold_off;      // long receiver hold-off request
    bit          burst_mode;    // sender idles at random when set

    // clock and cycle watchdog
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned live_count();
        int unsigned n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += live_q[i];
        return n;
    endfunction

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (live_q[i] && key_q[i] == k) return i;
        return -1;
    endfunction

    function automatic int lru_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (live_q[i] && (best < 0 || rank_q[i] > rank_q[best])) best = i;
        return best;
    endfunction

    function automatic void drop_slot(int s);
        int unsigned r;
        r = rank_q[s];
        held_q = held_q - size_q[s];
        live_q[s] = 0;
        rank_q[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (live_q[i] && rank_q[i] > r) rank_q[i]--;
    endfunction

    function automatic int unsigned evict_to_budget();
        int unsigned n;
        int s;
        n = 0;
        while (held_q > {1'b0, budget_q}) begin
            s = lru_slot();
            if (s < 0) break;
            drop_slot(s);
            n++;
        end
        return n;
    endfunction

    // predict one result and advance the shadow state
    function automatic t_out_item predict_cache(t_in_item it);
        t_out_item r;
        int s;
        int unsigned ev;
        int unsigned rk;
        r = '0;
        ev = 0;
        case (t_func'(it.func))
            FUNC_LOOKUP: begin
                s = find_slot(it.entry_key);
                if (s >= 0) begin
                    r.hit = 1'b1;
                    rk = rank_q[s];
                    for (int i = 0; i < SLOTS; i++)
                        if (live_q[i] && rank_q[i] < rk) rank_q[i]++;
                    rank_q[s] = 0;
                end
            end
            FUNC_KEEP: begin
                if (it.start_generation == gen_q && it.entry_bytes <= budget_q) begin
                    s = find_slot(it.entry_key);
                    if (s >= 0) drop_slot(s);
                    if (live_count() >= SLOTS) begin
                        s = lru_slot();
                        if (s >= 0) begin
                            drop_slot(s);
                            ev++;
                        end
                    end
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!live_q[i] && s < 0) s = i;
                    if (s >= 0) begin
                        for (int i = 0; i < SLOTS; i++)
                            if (live_q[i]) rank_q[i]++;
                        live_q[s] = 1;
                        key_q[s] = it.entry_key;
                        size_q[s] = it.entry_bytes;
                        rank_q[s] = 0;
                        held_q = held_q + 33'(it.entry_bytes);
                        r.stored = 1'b1;
                        ev += evict_to_budget();
                    end
                end
            end
            FUNC_TRIM: ev = evict_to_budget();
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    live_q[i] = 0;
                    rank_q[i] = 0;
                end
                held_q = '0;
                gen_q = gen_q + 32'd1;
            end
        endcase
        r.evicted_count = (ev > 31) ? 5'd31 : ev[4:0];
        r.total_bytes = held_q[31:0];
        r.entry_count = 5'(live_count());
        r.current_generation = gen_q;
        return r;
    endfunction

    // receiver: random stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off) begin
            i_out_stall <= 1'b1;
        end else begin
            case (cycle_count[9:8])
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // result checker against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no prediction waiting");
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_out_data.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_out_data.hit);
                    fail_count++;
                end
                if (o_out_data.stored !== e.stored) begin
                    $error("stored exp %0d got %0d", e.stored, o_out_data.stored);
                    fail_count++;
                end
                if (o_out_data.evicted_count !== e.evicted_count) begin
                    $error("evicted_count exp %0d got %0d",
                           e.evicted_count, o_out_data.evicted_count);
                    fail_count++;
                end
                if (o_out_data.total_bytes !== e.total_bytes) begin
                    $error("total_bytes exp %0h got %0h",
                           e.total_bytes, o_out_data.total_bytes);
                    fail_count++;
                end
                if (o_out_data.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d",
                           e.entry_count, o_out_data.entry_count);
                    fail_count++;
                end
                if (o_out_data.current_generation !== e.current_generation) begin
                    $error("current_generation exp %0h got %0h",
                           e.current_generation, o_out_data.current_generation);
                    fail_count++;
                end
            end
        end
    end

    // drop valid before the sender goes quiet
    task automatic idle_input();
        i_in_valid <= 1'b0;
    endtask

    // one input transfer; a random gap first when bursts are on
    // valid stays high after the transfer until the next item or an idle
    task automatic send_request(t_func f, logic [31:0] k, logic [31:0] b, logic [31:0] g);
        t_in_item it;
        it.func = f;
        it.entry_key = k;
        it.entry_bytes = b;
        it.start_generation = g;
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.insert(expected_results.size(), predict_cache(it));
    endtask

    // wait for the block to drain, then write the budget
    task automatic set_budget(logic [31:0] v);
        idle_input();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS * 40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        budget_q = v;
    endtask

    // keeps with random small sizes over a small key space
    task automatic keep_random(int n, int unsigned key_span, int unsigned size_max);
        for (int i = 0; i < n; i++)
            send_request(FUNC_KEEP, $urandom_range(0, key_span), $urandom_range(0, size_max), gen_q);
    endtask

    // directed: extremes, every func, each special case
    task automatic test_directed();
        set_budget(32'd100);
        send_request(FUNC_LOOKUP, 32'd5, '0, '0);                // miss on empty table
        send_request(FUNC_KEEP, 32'd5, 32'd40, 32'd0);
        send_request(FUNC_KEEP, 32'hFFFF_FFFF, 32'd50, 32'd0);
        send_request(FUNC_LOOKUP, 32'd5, '0, '0);                // hit, now most recent
        send_request(FUNC_KEEP, 32'd7, 32'd30, 32'd0);           // evicts the oldest
        send_request(FUNC_KEEP, 32'd9, 32'd101, 32'd0);          // oversized, refused
        send_request(FUNC_KEEP, 32'd9, 32'd1, 32'hFFFF_FFFF);    // stale, refused
        send_request(FUNC_KEEP, 32'd5, 32'd10, 32'd0);           // same key replaced
        send_request(FUNC_TRIM, '0, '0, '0);
        set_budget(32'd10);                                      // lowered without trim
        send_request(FUNC_LOOKUP, 32'd7, '0, '0);
        send_request(FUNC_TRIM, '0, '0, '0);
        set_budget(32'hFFFF_FFFF);
        send_request(FUNC_KEEP, 32'd1, 32'hFFFF_FFFF, 32'd0);    // biggest entry
        send_request(FUNC_KEEP, 32'd2, 32'd0, 32'd0);
        send_request(FUNC_RELOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS + 2; i++)                      // fill past full table
            send_request(FUNC_KEEP, 32'h100 + i, 32'd1, gen_q);
    endtask

    // generation wrap via many reloads is impractical; several reloads instead
    task automatic test_reloads();
        for (int i = 0; i < 4; i++) send_request(FUNC_RELOAD, $urandom, $urandom, $urandom);
        send_request(FUNC_KEEP, 32'd3, 32'd3, gen_q - 32'd1);    // stale after reload
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        burst_mode = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            keep_random(10, 20, 5);
        join
        burst_mode = 1;
    endtask

    // random phases under several budgets, including the extremes
    task automatic test_random();
        logic [31:0] budgets [6];
        t_func f;
        int unsigned roll;
        budgets = '{32'd0, 32'd64, 32'd300, 32'd1000, 32'h8000_0000, 32'hFFFF_FFFF};
        foreach (budgets[p]) begin
            set_budget(budgets[p]);
            burst_mode = (p % 2 == 0);
            for (int i = 0; i < 280; i++) begin
                roll = $urandom_range(0, 99);
                f = roll < 30 ? FUNC_LOOKUP : roll < 85 ? FUNC_KEEP :
                    roll < 96 ? FUNC_TRIM : FUNC_RELOAD;
                if (f == FUNC_KEEP && $urandom_range(0, 19) != 0)
                    send_request(f, $urandom_range(0, 40),
                                 ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120),
                                 gen_q);
                else if (f == FUNC_LOOKUP && $urandom_range(0, 4) != 0)
                    send_request(f, $urandom_range(0, 40), $urandom, $urandom);
                else
                    send_request(f, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        hold_off = 0;
        burst_mode = 1;
        fail_count = 0;
        budget_q = '0;
        held_q = '0;
        gen_q = '0;
        for (int i = 0; i < SLOTS; i++) begin
            live_q[i] = 0;
            rank_q[i] = 0;
            key_q[i] = '0;
            size_q[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_reloads();
        test_backpressure();
        test_random();

        idle_input();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS * 40) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/bblru_pkg.sv
rtl/bblru_slots.sv
rtl/byte_budget_lru_cache_top.sv
dv/tb_top.sv
